// File: hdl/quadratic_root_solver_core_defines.svh
// Assertion macros for the quadratic root solver core.
// Depends on nothing; included by the top level only.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Fixed-delay response check outside reset.
`define QRS_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) else $error(msg);

`endif

// File: hdl/qrs_pkg.sv
// Shared types, widths, codes and the clip function of the quadratic root solver.
// Depends on nothing.
package qrs_pkg;
   localparam int DATA_W  = 32;
   localparam int MAG_W   = 33;
   localparam int PROD_W  = 64;
   localparam int DISC_W  = 67;
   localparam int RAD_W   = 68;
   localparam int ROOT_W  = 34;
   localparam int SREM_W  = ROOT_W + 1;
   localparam int DEN_W   = 34;
   localparam int QUO_W   = 32;
   localparam int THR_W   = 16;
   localparam int STAT_W  = 2;

   localparam logic [STAT_W-1:0] STAT_NONE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_TWO    = 2'd2;

   typedef struct packed {
      logic valid;
      logic no_sol;
      logic single;
      logic neg_c;
      logic neg_h;
   } qrs_ctl_type;

   // {sat, value}: apply sign and clip a 32-bit magnitude (ovf: magnitude >= 2^32)
   function automatic logic [DATA_W:0] qrs_clip(input logic [QUO_W-1:0] q,
                                                input logic ovf, input logic neg);
      logic [QUO_W-1:0] m;
      logic             s;
      begin
         m = q;
         s = 1'b0;
         if (neg) begin
            if (ovf || q > 32'h8000_0000) begin
               m = 32'h8000_0000;
               s = 1'b1;
            end
            qrs_clip = {s, 32'd0 - m};
         end else begin
            if (ovf || q[QUO_W-1]) begin
               m = 32'h7FFF_FFFF;
               s = 1'b1;
            end
            qrs_clip = {s, m};
         end
      end
   endfunction
endpackage

// File: hdl/qrs_sqrt_step.sv
// One registered digit of the restoring integer square root.
// Depends on qrs_pkg.
module qrs_sqrt_step import qrs_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  qrs_ctl_type       ctl_in,
   input  logic [RAD_W-1:0]  rad_in,
   input  logic [SREM_W-1:0] rem_in,
   input  logic [ROOT_W-1:0] root_in,
   input  logic [DEN_W-1:0]  den_in,
   input  logic [MAG_W-1:0]  mb_in,
   output qrs_ctl_type       ctl_ff,
   output logic [RAD_W-1:0]  rad_ff,
   output logic [SREM_W-1:0] rem_ff,
   output logic [ROOT_W-1:0] root_ff,
   output logic [DEN_W-1:0]  den_ff,
   output logic [MAG_W-1:0]  mb_ff
);
   localparam int DIGIT = ROOT_W - 1 - STEP;

   logic [SREM_W+1:0] shifted;
   logic [SREM_W+1:0] trial;
   logic              ge;
   logic [SREM_W+1:0] diff;
   logic [SREM_W-1:0] rem_in_next;
   logic [ROOT_W-1:0] root_in_next;

   always_comb begin
      shifted      = {rem_in, rad_in[2*DIGIT+1 -: 2]};
      trial        = {1'b0, root_in, 2'b01};
      ge           = shifted >= trial;
      diff         = shifted - trial;
      rem_in_next  = ge ? diff[SREM_W-1:0] : shifted[SREM_W-1:0];
      root_in_next = {root_in[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.no_sol <= ctl_in.no_sol;
      ctl_ff.single <= ctl_in.single;
      ctl_ff.neg_c  <= ctl_in.neg_c;
      ctl_ff.neg_h  <= ctl_in.neg_h;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in_next;
      root_ff       <= root_in_next;
      den_ff        <= den_in;
      mb_ff         <= mb_in;
   end
endmodule

// File: hdl/qrs_div_step.sv
// One registered quotient bit for both the centre and the half-spread dividers.
// Depends on qrs_pkg.
module qrs_div_step import qrs_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  qrs_ctl_type      ctl_in,
   input  logic [DEN_W-1:0] den_in,
   input  logic [QUO_W-1:0] lo_c_in,
   input  logic [QUO_W-1:0] lo_h_in,
   input  logic [DEN_W-1:0] rem_c_in,
   input  logic [DEN_W-1:0] rem_h_in,
   input  logic [QUO_W-1:0] quo_c_in,
   input  logic [QUO_W-1:0] quo_h_in,
   input  logic [1:0]       ovf_in,
   output qrs_ctl_type      ctl_ff,
   output logic [DEN_W-1:0] den_ff,
   output logic [QUO_W-1:0] lo_c_ff,
   output logic [QUO_W-1:0] lo_h_ff,
   output logic [DEN_W-1:0] rem_c_ff,
   output logic [DEN_W-1:0] rem_h_ff,
   output logic [QUO_W-1:0] quo_c_ff,
   output logic [QUO_W-1:0] quo_h_ff,
   output logic [1:0]       ovf_ff
);
   localparam int BITPOS = QUO_W - 1 - STEP;

   logic [DEN_W:0] sh_c;
   logic [DEN_W:0] sh_h;
   logic [DEN_W:0] dn;
   logic           ge_c;
   logic           ge_h;
   logic [DEN_W:0] rem_c_in_next;
   logic [DEN_W:0] rem_h_in_next;

   always_comb begin
      dn            = {1'b0, den_in};
      sh_c          = {rem_c_in, lo_c_in[BITPOS]};
      sh_h          = {rem_h_in, lo_h_in[BITPOS]};
      ge_c          = sh_c >= dn;
      ge_h          = sh_h >= dn;
      rem_c_in_next = ge_c ? sh_c - dn : sh_c;
      rem_h_in_next = ge_h ? sh_h - dn : sh_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.no_sol <= ctl_in.no_sol;
      ctl_ff.single <= ctl_in.single;
      ctl_ff.neg_c  <= ctl_in.neg_c;
      ctl_ff.neg_h  <= ctl_in.neg_h;
      den_ff        <= den_in;
      lo_c_ff       <= lo_c_in;
      lo_h_ff       <= lo_h_in;
      rem_c_ff      <= rem_c_in_next[DEN_W-1:0];
      rem_h_ff      <= rem_h_in_next[DEN_W-1:0];
      quo_c_ff      <= {quo_c_in[QUO_W-2:0], ge_c};
      quo_h_ff      <= {quo_h_in[QUO_W-2:0], ge_h};
      ovf_ff        <= ovf_in;
   end
endmodule

// File: hdl/quadratic_root_solver_core.sv
// Quadratic root solver core: one transaction per cycle.
// Pipeline: four front stages, 34 root digits, divider set-up, 32 quotient bits, output register.
// Synchronous active-high reset clears every stage valid bit and loads threshold 7.
// The receiver cannot stall: each result is on the rsp_ ports for exactly one cycle.
`include "quadratic_root_solver_core_defines.svh"
module quadratic_root_solver_core import qrs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_coef_a,
   input  logic signed [DATA_W-1:0] req_coef_b,
   input  logic signed [DATA_W-1:0] req_coef_c,
   input  logic                     csr_write,
   input  logic [THR_W-1:0]         csr_wdata,
   output logic                     rsp_valid,
   output logic [STAT_W-1:0]        rsp_root_status,
   output logic signed [DATA_W-1:0] rsp_center,
   output logic signed [DATA_W-1:0] rsp_half_width,
   output logic                     rsp_saturated
);
   localparam int NUM_W   = ROOT_W + FRAC_BITS;
   localparam int HI_W    = NUM_W - QUO_W;
   localparam int LATENCY = 4 + ROOT_W + 1 + QUO_W + 1;
   localparam logic [DATA_W-1:0] HALF_NONE = ~((32'd1 << FRAC_BITS) - 32'd1);

   // Threshold register: user must write only while no transaction is in flight; not enforced.
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(7);
      end else if (csr_write) begin
         thr_ff <= csr_wdata;
      end
   end

   // The pipeline never backs up, so a start is always taken.
   assign busy = 1'b0;

   // Stage 0: capture the coefficients.
   logic              v0_ff;
   logic [DATA_W-1:0] a0_ff, b0_ff, c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      a0_ff <= req_coef_a;
      b0_ff <= req_coef_b;
      c0_ff <= req_coef_c;
   end

   // Stage 1: signs and 33-bit magnitudes (the most negative input needs the extra bit).
   logic             v1_ff, na1_ff, nb1_ff, nc1_ff;
   logic [MAG_W-1:0] ma1_ff, mb1_ff, mc1_ff;

   function automatic logic [MAG_W-1:0] mag_of(input logic [DATA_W-1:0] x);
      mag_of = x[DATA_W-1] ? (MAG_W'(0) - {1'b1, x}) : {1'b0, x};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      na1_ff <= a0_ff[DATA_W-1];
      nb1_ff <= b0_ff[DATA_W-1];
      nc1_ff <= c0_ff[DATA_W-1];
      ma1_ff <= mag_of(a0_ff);
      mb1_ff <= mag_of(b0_ff);
      mc1_ff <= mag_of(c0_ff);
   end

   // Stage 2: b*b and a*c, each kept to the low 64 bits.
   logic              v2_ff, na2_ff, nb2_ff, nc2_ff;
   logic [MAG_W-1:0]  ma2_ff, mb2_ff;
   logic [PROD_W-1:0] p2_ff, q2_ff;
   logic [2*MAG_W-1:0] pp_full, qq_full;

   always_comb begin
      pp_full = mb1_ff * mb1_ff;
      qq_full = ma1_ff * mc1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      na2_ff <= na1_ff;
      nb2_ff <= nb1_ff;
      nc2_ff <= nc1_ff;
      ma2_ff <= ma1_ff;
      mb2_ff <= mb1_ff;
      p2_ff  <= pp_full[PROD_W-1:0];
      q2_ff  <= qq_full[PROD_W-1:0];
   end

   // Stage 3: discriminant and the no-solution / single-root decisions.
   logic [PROD_W+1:0] q4;
   logic              qpos, dneg;
   logic [PROD_W+1:0] d_sub;
   logic [DISC_W-1:0] d_add, disc;
   logic              no_sol3, single3;
   qrs_ctl_type       ctl3_in;
   qrs_ctl_type       ctl3_ff;
   logic [RAD_W-1:0]  rad3_ff;
   logic [DEN_W-1:0]  den3_ff;
   logic [MAG_W-1:0]  mb3_ff;

   always_comb begin
      q4      = {q2_ff, 2'b00};
      qpos    = (|q2_ff) && (na2_ff == nc2_ff);
      dneg    = qpos && (q4 > {2'b00, p2_ff});
      d_sub   = {2'b00, p2_ff} - q4;
      d_add   = {3'b000, p2_ff} + {1'b0, q4};
      disc    = qpos ? {1'b0, d_sub} : d_add;
      no_sol3 = dneg || (ma2_ff == '0) || (ma2_ff < {{(MAG_W-THR_W){1'b0}}, thr_ff});
      single3 = disc < ({{(DISC_W-THR_W){1'b0}}, thr_ff} << FRAC_BITS);
      ctl3_in.valid  = v2_ff;
      ctl3_in.no_sol = no_sol3;
      ctl3_in.single = single3;
      ctl3_in.neg_c  = (nb2_ff == na2_ff);
      ctl3_in.neg_h  = na2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
      end else begin
         ctl3_ff.valid <= ctl3_in.valid;
      end
      ctl3_ff.no_sol <= ctl3_in.no_sol;
      ctl3_ff.single <= ctl3_in.single;
      ctl3_ff.neg_c  <= ctl3_in.neg_c;
      ctl3_ff.neg_h  <= ctl3_in.neg_h;
      rad3_ff        <= {1'b0, disc};
      den3_ff        <= {ma2_ff, 1'b0};
      mb3_ff         <= mb2_ff;
   end

   // Square root: one digit per stage, remainder and root advance down the chain.
   qrs_ctl_type       s_ctl  [ROOT_W+1];
   logic [RAD_W-1:0]  s_rad  [ROOT_W+1];
   logic [SREM_W-1:0] s_rem  [ROOT_W+1];
   logic [ROOT_W-1:0] s_root [ROOT_W+1];
   logic [DEN_W-1:0]  s_den  [ROOT_W+1];
   logic [MAG_W-1:0]  s_mb   [ROOT_W+1];

   assign s_ctl[0]  = ctl3_ff;
   assign s_rad[0]  = rad3_ff;
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;
   assign s_den[0]  = den3_ff;
   assign s_mb[0]   = mb3_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      qrs_sqrt_step #(.STEP(k)) u_step (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (s_ctl[k]),
         .rad_in  (s_rad[k]),
         .rem_in  (s_rem[k]),
         .root_in (s_root[k]),
         .den_in  (s_den[k]),
         .mb_in   (s_mb[k]),
         .ctl_ff  (s_ctl[k+1]),
         .rad_ff  (s_rad[k+1]),
         .rem_ff  (s_rem[k+1]),
         .root_ff (s_root[k+1]),
         .den_ff  (s_den[k+1]),
         .mb_ff   (s_mb[k+1])
      );
   end

   // Divider set-up: numerators are |b| and the square root, shifted up by FRAC_BITS.
   // A quotient of 2^32 or more is flagged here and clipped at the output stage.
   logic [NUM_W-1:0] num_c, num_h;
   logic [DEN_W-1:0] hi_c, hi_h;
   qrs_ctl_type      pre_ctl_ff;
   logic [DEN_W-1:0] pre_den_ff, pre_rem_c_ff, pre_rem_h_ff;
   logic [QUO_W-1:0] pre_lo_c_ff, pre_lo_h_ff;
   logic [1:0]       pre_ovf_ff;

   always_comb begin
      num_c = {{(NUM_W-MAG_W-FRAC_BITS){1'b0}}, s_mb[ROOT_W], {FRAC_BITS{1'b0}}};
      num_h = {s_root[ROOT_W], {FRAC_BITS{1'b0}}};
      hi_c  = {{(DEN_W-HI_W){1'b0}}, num_c[NUM_W-1:QUO_W]};
      hi_h  = {{(DEN_W-HI_W){1'b0}}, num_h[NUM_W-1:QUO_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ctl_ff.valid <= 1'b0;
      end else begin
         pre_ctl_ff.valid <= s_ctl[ROOT_W].valid;
      end
      pre_ctl_ff.no_sol <= s_ctl[ROOT_W].no_sol;
      pre_ctl_ff.single <= s_ctl[ROOT_W].single;
      pre_ctl_ff.neg_c  <= s_ctl[ROOT_W].neg_c;
      pre_ctl_ff.neg_h  <= s_ctl[ROOT_W].neg_h;
      pre_den_ff        <= s_den[ROOT_W];
      pre_rem_c_ff      <= hi_c;
      pre_rem_h_ff      <= hi_h;
      pre_lo_c_ff       <= num_c[QUO_W-1:0];
      pre_lo_h_ff       <= num_h[QUO_W-1:0];
      pre_ovf_ff        <= {hi_h >= s_den[ROOT_W], hi_c >= s_den[ROOT_W]};
   end

   // Dividers: one quotient bit per stage for both numerators.
   qrs_ctl_type      d_ctl   [QUO_W+1];
   logic [DEN_W-1:0] d_den   [QUO_W+1];
   logic [QUO_W-1:0] d_lo_c  [QUO_W+1];
   logic [QUO_W-1:0] d_lo_h  [QUO_W+1];
   logic [DEN_W-1:0] d_rem_c [QUO_W+1];
   logic [DEN_W-1:0] d_rem_h [QUO_W+1];
   logic [QUO_W-1:0] d_quo_c [QUO_W+1];
   logic [QUO_W-1:0] d_quo_h [QUO_W+1];
   logic [1:0]       d_ovf   [QUO_W+1];

   assign d_ctl[0]   = pre_ctl_ff;
   assign d_den[0]   = pre_den_ff;
   assign d_lo_c[0]  = pre_lo_c_ff;
   assign d_lo_h[0]  = pre_lo_h_ff;
   assign d_rem_c[0] = pre_rem_c_ff;
   assign d_rem_h[0] = pre_rem_h_ff;
   assign d_quo_c[0] = '0;
   assign d_quo_h[0] = '0;
   assign d_ovf[0]   = pre_ovf_ff;

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      qrs_div_step #(.STEP(j)) u_step (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (d_ctl[j]),
         .den_in   (d_den[j]),
         .lo_c_in  (d_lo_c[j]),
         .lo_h_in  (d_lo_h[j]),
         .rem_c_in (d_rem_c[j]),
         .rem_h_in (d_rem_h[j]),
         .quo_c_in (d_quo_c[j]),
         .quo_h_in (d_quo_h[j]),
         .ovf_in   (d_ovf[j]),
         .ctl_ff   (d_ctl[j+1]),
         .den_ff   (d_den[j+1]),
         .lo_c_ff  (d_lo_c[j+1]),
         .lo_h_ff  (d_lo_h[j+1]),
         .rem_c_ff (d_rem_c[j+1]),
         .rem_h_ff (d_rem_h[j+1]),
         .quo_c_ff (d_quo_c[j+1]),
         .quo_h_ff (d_quo_h[j+1]),
         .ovf_ff   (d_ovf[j+1])
      );
   end

   // Output stage: sign, clip and pick the special cases.
   qrs_ctl_type       fin;
   logic [DATA_W:0]   clip_c, clip_h;
   logic [STAT_W-1:0] status_in;
   logic [DATA_W-1:0] center_in, half_in;
   logic              sat_in;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_center_ff, rsp_half_ff;
   logic              rsp_sat_ff;

   always_comb begin
      fin    = d_ctl[QUO_W];
      clip_c = qrs_clip(d_quo_c[QUO_W], d_ovf[QUO_W][0], fin.neg_c);
      clip_h = qrs_clip(d_quo_h[QUO_W], d_ovf[QUO_W][1], fin.neg_h);
      if (fin.no_sol) begin
         status_in = STAT_NONE;
         center_in = '0;
         half_in   = HALF_NONE;
         sat_in    = 1'b0;
      end else if (fin.single) begin
         status_in = STAT_SINGLE;
         center_in = clip_c[DATA_W-1:0];
         half_in   = '0;
         sat_in    = clip_c[DATA_W];
      end else begin
         status_in = STAT_TWO;
         center_in = clip_c[DATA_W-1:0];
         half_in   = clip_h[DATA_W-1:0];
         sat_in    = clip_c[DATA_W] | clip_h[DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
      rsp_status_ff <= status_in;
      rsp_center_ff <= center_in;
      rsp_half_ff   <= half_in;
      rsp_sat_ff    <= sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_status = rsp_status_ff;
   assign rsp_center      = rsp_center_ff;
   assign rsp_half_width  = rsp_half_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // Every accepted transaction yields its strobe after the fixed latency.
   `QRS_ASSERT_DELAY(a_latency, start && !busy, LATENCY, rsp_valid, "result strobe missing")
   // No-solution results carry the fixed centre, half-spread and saturation values.
   `QRS_ASSERT_IMPL(a_no_sol, rsp_valid && rsp_root_status == STAT_NONE, rsp_center == '0 && rsp_half_width == HALF_NONE && !rsp_saturated, "bad no-solution result")
   // A single root has zero half-spread.
   `QRS_ASSERT_IMPL(a_single, rsp_valid && rsp_root_status == STAT_SINGLE, rsp_half_width == '0, "single root with spread")
endmodule
